>>> design/inv3_pkg.sv
`default_nettype none
package inv3_pkg;

    localparam int EW    = 32;        // element / result width
    localparam int PW    = 2 * EW;    // element product
    localparam int CW    = PW + 1;    // cofactor, signed
    localparam int MW    = PW;        // cofactor magnitude
    localparam int DW    = 96;        // divisor magnitude (determinant is below 2^96)
    localparam int TW    = DW + 2;    // signed determinant terms and sum
    localparam int THW   = 16;        // threshold register
    localparam int NEL   = 9;
    localparam int NDIV  = EW;        // one quotient bit per divider stage
    localparam int NFRT  = 5;         // front stages before the dividers
    localparam int DLAT  = NDIV + 2;  // divider: input, steps, result
    localparam int NSTG  = NFRT + DLAT + 1;

    localparam logic [THW-1:0] PIVOT_RST = 16'd33;

    // element indices, row then column
    localparam int XX = 0;
    localparam int XY = 1;
    localparam int XZ = 2;
    localparam int YY = 4;
    localparam int ZZ = 8;

    typedef logic signed [EW-1:0] elem_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [CW-1:0] cof_t;
    typedef logic signed [TW-1:0] term_t;

    // cofactor k = e[a]*e[b] - e[c]*e[d]
    typedef int unsigned cof_idx_t [0:NEL-1][0:3];
    localparam cof_idx_t COF_IDX = '{
        '{4, 8, 5, 7}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
        '{5, 6, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
        '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic [MW-1:0] num;
        logic [DW-1:0] den;
        logic          neg;
        logic          sat;
    } div_in_t;

endpackage
`default_nettype wire

>>> design/inv3_div.sv
`default_nettype none
module inv3_div import inv3_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    en,
    input  wire div_in_t div_i,
    output elem_t        res_o
);

    logic [DW-1:0] rem_reg [0:NDIV];
    logic [DW-1:0] den_reg [0:NDIV];
    logic [EW-1:0] q_reg   [0:NDIV];
    logic          neg_reg [0:NDIV];
    logic          sat_reg [0:NDIV];
    logic [DW-1:0] rem_next [0:NDIV-1];
    logic          ge       [0:NDIV-1];
    logic [DW:0]   r2       [0:NDIV-1];
    logic [DW:0]   diff     [0:NDIV-1];
    logic [EW-1:0] lim;
    logic [EW-1:0] mag;
    elem_t         res_reg;
    elem_t         res_next;

    always_comb begin
        for (int i = 0; i < NDIV; i++) begin
            r2[i]       = {rem_reg[i], 1'b0};
            diff[i]     = r2[i] - {1'b0, den_reg[i]};
            ge[i]       = r2[i] >= {1'b0, den_reg[i]};
            rem_next[i] = ge[i] ? diff[i][DW-1:0] : r2[i][DW-1:0];
        end
    end

    // quotient fits 32 bits only when num < den; otherwise saturate, and clamp to the signed range
    always_comb begin
        lim      = neg_reg[NDIV] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
        mag      = (sat_reg[NDIV] || q_reg[NDIV] > lim) ? lim : q_reg[NDIV];
        res_next = neg_reg[NDIV] ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {{(DW-MW){1'b0}}, div_i.num};
            den_reg[0] <= div_i.den;
            q_reg[0]   <= '0;
            neg_reg[0] <= div_i.neg;
            sat_reg[0] <= div_i.sat;
            for (int i = 0; i < NDIV; i++) begin
                rem_reg[i+1] <= rem_next[i];
                den_reg[i+1] <= den_reg[i];
                q_reg[i+1]   <= {q_reg[i][EW-2:0], ge[i]};
                neg_reg[i+1] <= neg_reg[i];
                sat_reg[i+1] <= sat_reg[i];
            end
            res_reg <= res_next;
        end
    end

    assign res_o = res_reg;

endmodule
`default_nettype wire

>>> design/inverse_3x3_with_singular_check.sv
`default_nettype none
// 3x3 inverse of a signed Q16.16 matrix by adjugate over determinant, with a
// diagonal-only shortcut (reciprocal of each diagonal element). Accepts one
// matrix per clock unless stalled; most of the pipeline is the nine 32-stage
// dividers, which retire one quotient bit per stage. The whole pipeline holds
// while a result waits on m_ready. singular is raised (and all outputs zero)
// when a diagonal element of a diagonal input, or else the determinant, is
// zero or below pivot_reg, written via cfg_we/cfg_wdata (reset 33).
module inverse_3x3_with_singular_check import inv3_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire elem_t       s_in_xx,
    input  wire elem_t       s_in_xy,
    input  wire elem_t       s_in_xz,
    input  wire elem_t       s_in_yx,
    input  wire elem_t       s_in_yy,
    input  wire elem_t       s_in_yz,
    input  wire elem_t       s_in_zx,
    input  wire elem_t       s_in_zy,
    input  wire elem_t       s_in_zz,
    output logic             m_valid,
    input  wire logic        m_ready,
    output elem_t            m_inv_xx,
    output elem_t            m_inv_xy,
    output elem_t            m_inv_xz,
    output elem_t            m_inv_yx,
    output elem_t            m_inv_yy,
    output elem_t            m_inv_yz,
    output elem_t            m_inv_zx,
    output elem_t            m_inv_zy,
    output elem_t            m_inv_zz,
    output logic             m_singular
);

    logic [THW-1:0] pivot_reg;
    logic           vld_reg [0:NSTG-1];
    logic           adv;

    elem_t in_e [0:NEL-1];
    logic  diag_in;
    logic  dsing_in;

    elem_t  e_reg     [1:NFRT][0:NEL-1];
    logic   diag_reg  [1:NFRT];
    logic   dsing_reg [1:NFRT];
    prod_t  p_reg     [0:2*NEL-1];
    cof_t   cof_reg   [2:NFRT][0:NEL-1];
    logic [PW-1:0] ppl_reg [0:2];
    logic [PW-1:0] pph_reg [0:2];
    logic          tneg_reg [0:2];
    term_t         term_reg [0:2];
    term_t         det_reg;

    logic [CW-1:0] mc   [0:2];
    logic [EW:0]   me   [0:2];
    logic [DW-1:0] tmag [0:2];

    logic          sing;
    term_t         thr;
    div_in_t       div_in [0:NEL-1];
    logic [CW-1:0] cmag   [0:NEL-1];
    elem_t         res    [0:NEL-1];
    logic          sd_reg [0:DLAT-1];
    elem_t         out_reg [0:NEL-1];
    logic          out_sing_reg;

    assign adv     = !vld_reg[NSTG-1] || m_ready;
    assign s_ready = adv;

    always_comb begin
        in_e[0] = s_in_xx; in_e[1] = s_in_xy; in_e[2] = s_in_xz;
        in_e[3] = s_in_yx; in_e[4] = s_in_yy; in_e[5] = s_in_yz;
        in_e[6] = s_in_zx; in_e[7] = s_in_zy; in_e[8] = s_in_zz;
        diag_in = (s_in_xy == '0) && (s_in_yx == '0) && (s_in_xz == '0) &&
                  (s_in_zx == '0) && (s_in_yz == '0) && (s_in_zy == '0);
        dsing_in = 1'b0;
        for (int j = 0; j < 3; j++) begin
            if (in_e[4*j] < $signed({{(EW-THW){1'b0}}, pivot_reg}) || in_e[4*j] == '0) begin
                dsing_in = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pivot_reg <= PIVOT_RST;
        end else if (cfg_we) begin
            pivot_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSTG; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < NSTG; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // front: products, cofactors, partial products, terms, determinant
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            mc[j]   = cof_reg[2][3*j][CW-1] ? -cof_reg[2][3*j] : cof_reg[2][3*j];
            me[j]   = e_reg[2][j][EW-1] ? -{1'b1, e_reg[2][j]} : {1'b0, e_reg[2][j]};
            tmag[j] = {{(DW-PW){1'b0}}, ppl_reg[j]} + {pph_reg[j], {EW{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NEL; k++) begin
                p_reg[2*k]   <= in_e[COF_IDX[k][0]] * in_e[COF_IDX[k][1]];
                p_reg[2*k+1] <= in_e[COF_IDX[k][2]] * in_e[COF_IDX[k][3]];
                cof_reg[2][k] <= CW'(p_reg[2*k]) - CW'(p_reg[2*k+1]);
            end
            e_reg[1]     <= in_e;
            diag_reg[1]  <= diag_in;
            dsing_reg[1] <= dsing_in;
            for (int s = 2; s <= NFRT; s++) begin
                e_reg[s]     <= e_reg[s-1];
                diag_reg[s]  <= diag_reg[s-1];
                dsing_reg[s] <= dsing_reg[s-1];
            end
            for (int s = 3; s <= NFRT; s++) begin
                cof_reg[s] <= cof_reg[s-1];
            end
            for (int j = 0; j < 3; j++) begin
                ppl_reg[j]  <= mc[j][EW-1:0] * me[j][EW-1:0];
                pph_reg[j]  <= mc[j][PW-1:EW] * me[j][EW-1:0];
                tneg_reg[j] <= cof_reg[2][3*j][CW-1] ^ e_reg[2][j][EW-1];
                term_reg[j] <= tneg_reg[j] ? -$signed({2'b00, tmag[j]})
                                           : $signed({2'b00, tmag[j]});
            end
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
        end
    end

    // divider setup: 1/d or 0 per lane if diagonal, else cofactor/det
    always_comb begin
        thr  = $signed({{(TW-THW-EW){1'b0}}, pivot_reg, {EW{1'b0}}});
        sing = diag_reg[NFRT] ? dsing_reg[NFRT]
             : (det_reg[TW-1] || det_reg < thr || det_reg == '0);
        for (int k = 0; k < NEL; k++) begin
            cmag[k] = cof_reg[NFRT][k][CW-1] ? -cof_reg[NFRT][k] : cof_reg[NFRT][k];
            if (diag_reg[NFRT]) begin
                if (k == XX || k == YY || k == ZZ) begin
                    div_in[k].num = MW'(1);
                    div_in[k].den = {{(DW-EW){1'b0}}, e_reg[NFRT][k]};
                end else begin
                    div_in[k].num = '0;
                    div_in[k].den = DW'(1);
                end
                div_in[k].neg = 1'b0;
            end else begin
                div_in[k].num = cmag[k][MW-1:0];
                div_in[k].den = det_reg[DW-1:0];
                div_in[k].neg = cof_reg[NFRT][k][CW-1];
            end
            div_in[k].sat = {{(DW-MW){1'b0}}, div_in[k].num} >= div_in[k].den;
        end
    end

    for (genvar k = 0; k < NEL; k++) begin : g_lane
        inv3_div u_div (
            .aclk  (aclk),
            .en    (adv),
            .div_i (div_in[k]),
            .res_o (res[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sd_reg[0] <= sing;
            for (int i = 1; i < DLAT; i++) begin
                sd_reg[i] <= sd_reg[i-1];
            end
            for (int k = 0; k < NEL; k++) begin
                out_reg[k] <= sd_reg[DLAT-1] ? '0 : res[k];
            end
            out_sing_reg <= sd_reg[DLAT-1];
        end
    end

    assign m_valid    = vld_reg[NSTG-1];
    assign m_inv_xx   = out_reg[0];
    assign m_inv_xy   = out_reg[1];
    assign m_inv_xz   = out_reg[2];
    assign m_inv_yx   = out_reg[3];
    assign m_inv_yy   = out_reg[4];
    assign m_inv_yz   = out_reg[5];
    assign m_inv_zx   = out_reg[6];
    assign m_inv_zy   = out_reg[7];
    assign m_inv_zz   = out_reg[8];
    assign m_singular = out_sing_reg;

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench import inv3_pkg::*;;

    typedef struct {
        elem_t e [0:8];
    } matrix_t;

    typedef struct {
        elem_t v [0:8];
        logic  sing;
    } inverse_t;

    localparam int STALL_LIMIT = 4000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    elem_t       s_el [0:8] = '{default: '0};
    logic        m_valid;
    logic        m_ready = 1'b0;
    elem_t       m_el [0:8];
    logic        m_singular;

    matrix_t     pending_mats [$];
    inverse_t    expected_invs [$];
    logic [15:0] pivot = PIVOT_RST;
    bit          no_idle = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          errors = 0;
    int          quiet_cycles = 0;

    inverse_3x3_with_singular_check dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_xx(s_el[0]), .s_in_xy(s_el[1]), .s_in_xz(s_el[2]),
        .s_in_yx(s_el[3]), .s_in_yy(s_el[4]), .s_in_yz(s_el[5]),
        .s_in_zx(s_el[6]), .s_in_zy(s_el[7]), .s_in_zz(s_el[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_inv_xx(m_el[0]), .m_inv_xy(m_el[1]), .m_inv_xz(m_el[2]),
        .m_inv_yx(m_el[3]), .m_inv_yy(m_el[4]), .m_inv_yz(m_el[5]),
        .m_inv_zx(m_el[6]), .m_inv_zy(m_el[7]), .m_inv_zz(m_el[8]),
        .m_singular(m_singular)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic inverse_t invert(matrix_t m, logic [15:0] thr);
        inverse_t r;
        logic signed [127:0] w [0:8];
        logic signed [127:0] cof [0:8];
        logic signed [127:0] det;
        logic signed [127:0] q;
        bit diag;
        for (int k = 0; k < 9; k++) begin
            w[k] = m.e[k];
            r.v[k] = '0;
        end
        r.sing = 1'b0;
        diag = w[1] == 0 && w[2] == 0 && w[3] == 0 && w[5] == 0 && w[6] == 0 && w[7] == 0;
        if (diag) begin
            for (int k = 0; k < 9; k += 4) begin
                if (w[k] < $signed({1'b0, thr}) || w[k] == 0) r.sing = 1'b1;
            end
            if (r.sing) return r;
            for (int k = 0; k < 9; k += 4) begin
                q = (128'sd1 <<< 32) / w[k];
                r.v[k] = q > 128'sh7FFFFFFF ? 32'sh7FFFFFFF : q[31:0];
            end
            return r;
        end
        cof[0] = w[4] * w[8] - w[5] * w[7];
        cof[1] = w[7] * w[2] - w[1] * w[8];
        cof[2] = w[1] * w[5] - w[4] * w[2];
        cof[3] = w[5] * w[6] - w[3] * w[8];
        cof[4] = w[0] * w[8] - w[6] * w[2];
        cof[5] = w[3] * w[2] - w[0] * w[5];
        cof[6] = w[3] * w[7] - w[6] * w[4];
        cof[7] = w[6] * w[1] - w[0] * w[7];
        cof[8] = w[0] * w[4] - w[1] * w[3];
        det = cof[0] * w[0] + cof[3] * w[1] + cof[6] * w[2];
        if (det <= 0 || det < ($signed({112'd0, thr}) <<< 32)) begin
            r.sing = 1'b1;
            return r;
        end
        for (int k = 0; k < 9; k++) begin
            q = (cof[k] <<< 32) / det;
            if (q > 128'sh7FFFFFFF) r.v[k] = 32'sh7FFFFFFF;
            else if (q < -128'sh80000000) r.v[k] = 32'sh80000000;
            else r.v[k] = q[31:0];
        end
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        matrix_t nxt;
        if (aresetn && !(s_valid && !s_ready)) begin
            if (s_valid) begin
                expected_invs.push_back(invert(pending_mats[0], pivot));
                void'(pending_mats.pop_front());
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_mats.size() > 0) begin
                nxt = pending_mats[0];
                for (int k = 0; k < 9; k++) s_el[k] <= nxt.e[k];
                s_valid <= 1'b1;
                gap_left <= no_idle ? 0 : $urandom_range(0, 18);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        inverse_t want;
        int draw;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_invs.size() == 0) begin
                    $display("%0t: unexpected result transaction", $time);
                    errors++;
                end else begin
                    want = expected_invs.pop_front();
                    for (int k = 0; k < 9; k++) begin
                        if (m_el[k] !== want.v[k]) begin
                            $display("%0t: inv[%0d] expected %h actual %h",
                                     $time, k, want.v[k], m_el[k]);
                            errors++;
                        end
                    end
                    if (m_singular !== want.sing) begin
                        $display("%0t: singular expected %b actual %b",
                                 $time, want.sing, m_singular);
                        errors++;
                    end
                end
                draw = no_idle ? 0 : $urandom_range(0, 18);
                // the cycle after this edge already counts as the first idle one
                stall_left <= draw > 0 ? draw - 1 : 0;
                m_ready <= draw == 0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: only counts while work is outstanding
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (pending_mats.size() == 0 && expected_invs.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic matrix_t diag_mat(elem_t a, elem_t b, elem_t c);
        matrix_t m;
        m.e = '{default: '0};
        m.e[0] = a;
        m.e[4] = b;
        m.e[8] = c;
        return m;
    endfunction

    function automatic matrix_t random_mat();
        matrix_t m;
        int sel;
        sel = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++) m.e[k] = $urandom;
        if (sel < 4) begin
            // diagonal shortcut, mostly sensible magnitudes
            for (int k = 0; k < 3; k++) begin
                if ($urandom_range(0, 3) == 0) m.e[4 * k] = $urandom;
                else m.e[4 * k] = $urandom_range(0, 20) == 0 ? -$urandom_range(0, 70000)
                                                              : $urandom_range(0, 1 << 20);
            end
            for (int k = 0; k < 9; k++) if (k % 4 != 0) m.e[k] = '0;
        end else if (sel < 8) begin
            // near-identity, well conditioned
            for (int k = 0; k < 9; k++) begin
                m.e[k] = $signed($urandom_range(0, 1 << 15)) - (1 << 14);
                if (k % 4 == 0) m.e[k] = m.e[k] + ($urandom_range(0, 7) == 0 ? -65536 : 65536)
                                         * $urandom_range(1, 4);
            end
            if ($urandom_range(0, 3) == 0) m.e[$urandom_range(0, 8)] = $urandom;
        end
        return m;
    endfunction

    task automatic drain();
        while (pending_mats.size() > 0 || expected_invs.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic set_pivot(logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        pivot = val;
    endtask

    initial begin
        matrix_t m;
        logic [15:0] pivots [0:4];
        pivots = '{16'd33, 16'd0, 16'hFFFF, 16'd33, 16'd0};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: identity, diagonal edges, full-scale extremes, small non-diagonal matrices
        pending_mats.push_back(diag_mat(32'sh10000, 32'sh10000, 32'sh10000));
        pending_mats.push_back(diag_mat(32'sh7FFFFFFF, 32'sd1, 32'sh10000));
        pending_mats.push_back(diag_mat(32'sd33, 32'sd32, 32'sh10000));
        pending_mats.push_back(diag_mat(32'sd0, 32'sh10000, 32'sh10000));
        pending_mats.push_back(diag_mat(32'sh80000000, 32'sh10000, 32'sh10000));
        pending_mats.push_back(diag_mat(32'sd2, 32'sd33, 32'sd34));
        m.e = '{default: 32'sh7FFFFFFF};
        pending_mats.push_back(m);
        m.e = '{default: 32'sh80000000};
        pending_mats.push_back(m);
        m.e = '{32'sh80000000, 32'sd0, 32'sd0, 32'sd0, 32'sh7FFFFFFF, 32'sd1,
                32'sd0, 32'sd0, 32'sh80000000};
        pending_mats.push_back(m);
        m.e = '{32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd1, 32'sd0, 32'sd1};
        pending_mats.push_back(m);
        m.e = '{32'sh10000, 32'sh10000, 32'sd0, 32'sd0, 32'sh10000, 32'sd0,
                32'sd0, 32'sd0, 32'sh10000};
        pending_mats.push_back(m);
        m.e = '{32'sd0, 32'sh10000, 32'sd0, 32'sh10000, 32'sd0, 32'sd0,
                32'sd0, 32'sd0, 32'sh10000};
        pending_mats.push_back(m);
        m.e = '{32'sd0, 32'sh10000, 32'sd0, 32'sh10000, 32'sd0, 32'sd0,
                32'sd0, 32'sd0, -32'sh10000};
        pending_mats.push_back(m);
        m.e = '{32'sh100, 32'sd1, 32'sd0, 32'sd0, 32'sh100, 32'sd0, 32'sd0, 32'sd0, 32'sh100};
        pending_mats.push_back(m);
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) set_pivot(ph == 3 ? 16'($urandom) : pivots[ph]);
            if (ph == 1) begin
                pending_mats.push_back(diag_mat(32'sd0, 32'sd1, 32'sd1));
                pending_mats.push_back(diag_mat(32'sd1, 32'sd1, 32'sd1));
                m.e = '{32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1};
                pending_mats.push_back(m);
            end
            no_idle = ph == 2;
            for (int i = 0; i < 400; i++) pending_mats.push_back(random_mat());
            drain();
        end
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> inverse_3x3_with_singular_check.f
design/inv3_pkg.sv
design/inv3_div.sv
design/inverse_3x3_with_singular_check.sv
tb/sv/testbench.sv
